@@ rtl/lrc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lrc_pkg
// Shared codes and types of the block cache tag manager.
// ---------------------------------------------------------------------------
package lrc_pkg;

   // result kinds
   localparam logic [1:0] KIND_HIT   = 2'd0;
   localparam logic [1:0] KIND_ALLOC = 2'd1;
   localparam logic [1:0] KIND_INV   = 2'd2;

   // request ops
   localparam logic OP_READ = 1'b0;
   localparam logic OP_INV  = 1'b1;

   // width of block counters (counts up to 63)
   localparam int CNT_W = 6;

   // what a probe looks for as it walks the cells
   typedef enum logic {
      PROBE_LOOKUP,
      PROBE_VICTIM
   } lrc_probe_type;

   // write strobes broadcast to every cell
   typedef struct packed {
      logic clr_valid;
      logic clr_picked;
      logic stamp;
      logic alloc;
   } lrc_wr_type;

endpackage
`default_nettype wire

@@ rtl/lrc_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lrc_cell
// One cache entry: tag, valid, stamp and burst pick mark. A probe passes
// through each cycle and picks up a hit or a better victim on its way.
// ---------------------------------------------------------------------------
module lrc_cell
   import lrc_pkg::*;
#(
   parameter int IW         = 4,
   parameter int BLOCK_BITS = 32,
   parameter int IDX        = 0
) (
   input  wire                   clock,
   input  wire                   reset,
   input  lrc_wr_type            wr,
   input  wire  [IW-1:0]         wr_idx,
   input  wire  [BLOCK_BITS-1:0] wr_tag,
   input  wire  [31:0]           wr_stamp,
   input  wire                   p_valid_i,
   input  lrc_probe_type         p_mode_i,
   input  wire  [BLOCK_BITS-1:0] p_key_i,
   input  wire                   p_found_i,
   input  wire  [IW-1:0]         p_idx_i,
   input  wire  [31:0]           p_stamp_i,
   input  wire                   p_inv_i,
   output logic                  p_valid_o,
   output lrc_probe_type         p_mode_o,
   output logic [BLOCK_BITS-1:0] p_key_o,
   output logic                  p_found_o,
   output logic [IW-1:0]         p_idx_o,
   output logic [31:0]           p_stamp_o,
   output logic                  p_inv_o
);

   logic [BLOCK_BITS-1:0] tag_ff;
   logic [31:0]           stamp_ff;
   logic                  valid_ff;
   logic                  picked_ff;
   logic                  take;
   logic                  me;

   assign me = (wr_idx == IW'(IDX));

   // entry state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         picked_ff <= 1'b0;
      end else begin
         if (wr.clr_valid) valid_ff <= 1'b0;
         if (wr.clr_picked) picked_ff <= 1'b0;
         if (me && wr.stamp) stamp_ff <= wr_stamp;
         if (me && wr.alloc) begin
            tag_ff    <= wr_tag;
            stamp_ff  <= wr_stamp;
            valid_ff  <= 1'b1;
            picked_ff <= 1'b1;
         end
      end
   end

   // does this cell replace what the probe carries
   always_comb begin
      take = 1'b0;
      unique case (p_mode_i)
         PROBE_LOOKUP: take = !p_found_i && valid_ff && (tag_ff == p_key_i);
         PROBE_VICTIM: begin
            if (!picked_ff) begin
               // free entries win, the first one in index order
               if (!valid_ff) take = !(p_found_i && p_inv_i);
               else take = !p_found_i || (!p_inv_i && (stamp_ff < p_stamp_i));
            end
         end
         default: take = 1'b0;
      endcase
   end

   // probe stage
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_o <= 1'b0;
      end else begin
         p_valid_o <= p_valid_i;
      end
      p_mode_o <= p_mode_i;
      p_key_o  <= p_key_i;
      if (take) begin
         p_found_o <= 1'b1;
         p_idx_o   <= IW'(IDX);
         p_stamp_o <= stamp_ff;
         p_inv_o   <= !valid_ff;
      end else begin
         p_found_o <= p_found_i;
         p_idx_o   <= p_idx_i;
         p_stamp_o <= p_stamp_i;
         p_inv_o   <= p_inv_i;
      end
   end

endmodule
`default_nettype wire

@@ rtl/lru_block_cache_readahead_alloc.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lru_block_cache_readahead_alloc
// Tag and LRU replacement manager for a fully associative block cache.
// ---------------------------------------------------------------------------
// Each entry lives in a cell of a chain; a probe walks the chain one cell
// per cycle, and every lookup and every victim pick is one such walk. A
// read takes the word and decodes it, then walks once per hit and for the
// lookup that misses, once per allocated entry (READAHEAD or ENTRIES per
// burst, whichever is smaller) and passes S_BURST_GO once per burst; an
// invalidate takes the word and posts its result. A result that waits in
// the output register holds the sequencer for as long as it waits. One
// request is worked at a time; the next word is taken while the last result
// still waits in the output register.
module lru_block_cache_readahead_alloc
   import lrc_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int READAHEAD  = 12,
   parameter int BLOCK_BITS = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,  // start_block[31:0], block_count[35:32], zero pad
   input  wire         req_tuser,  // op
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,  // entry_index[3:0], tag_block[35:4], fill_offset[39:36]
   output logic [1:0]  rsp_tuser,  // kind
   output logic        rsp_tlast
);

   localparam int IW    = $clog2(ENTRIES);
   localparam int BURST = (READAHEAD < ENTRIES) ? READAHEAD : ENTRIES;
   localparam logic [CNT_W-1:0] BURST_C = CNT_W'(BURST);
   localparam logic [CNT_W-1:0] RA_C    = CNT_W'(READAHEAD);

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_LOOK_GO, S_LOOK_WAIT, S_LOOK_DONE,
      S_BURST_GO, S_PICK_GO, S_PICK_WAIT, S_PICK_DONE
   } state_type;

   state_type             state_ff;
   logic                  op_ff;
   logic [BLOCK_BITS-1:0] blk_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      n_ff;
   logic [31:0]           clock_ff;
   logic                  res_found_ff;
   logic [IW-1:0]         res_idx_ff;
   logic                  rsp_valid_ff;
   logic [1:0]            kind_ff;
   logic [3:0]            idx_out_ff;
   logic [31:0]           tag_out_ff;
   logic [3:0]            off_out_ff;
   logic                  last_ff;

   // probe chain
   logic                  p_valid [ENTRIES+1];
   lrc_probe_type         p_mode  [ENTRIES+1];
   logic [BLOCK_BITS-1:0] p_key   [ENTRIES+1];
   logic                  p_found [ENTRIES+1];
   logic [IW-1:0]         p_idx   [ENTRIES+1];
   logic [31:0]           p_stamp [ENTRIES+1];
   logic                  p_inv   [ENTRIES+1];

   lrc_wr_type            wr;
   logic                  out_free;
   logic                  post_word;
   logic [BLOCK_BITS-1:0] alloc_tag;
   logic [BLOCK_BITS-1:0] tag_sel;
   logic [BLOCK_BITS+31:0] tag_ext;
   logic [IW+3:0]         idx_ext;
   logic [BLOCK_BITS+31:0] blk_ext;
   logic [CNT_W-1:0]      cnt_req;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign alloc_tag = blk_ff + BLOCK_BITS'(n_ff);
   assign tag_sel   = (state_ff == S_PICK_DONE) ? alloc_tag : blk_ff;
   assign tag_ext   = {32'd0, tag_sel};
   assign idx_ext   = {4'd0, res_idx_ff};
   assign blk_ext   = {BLOCK_BITS'(0), req_tdata[31:0]};

   // a result word is loaded into the output register this cycle
   assign post_word = out_free &&
                      (((state_ff == S_START) && (op_ff == OP_INV)) ||
                       ((state_ff == S_LOOK_DONE) && res_found_ff) ||
                       (state_ff == S_PICK_DONE));

   // saturate the count to the readahead length
   always_comb begin
      cnt_req = {{(CNT_W-4){1'b0}}, req_tdata[35:32]};
      if (cnt_req > RA_C) cnt_req = RA_C;
   end

   // write strobes
   always_comb begin
      wr.clr_valid  = (state_ff == S_START) && (op_ff == OP_INV) && out_free;
      wr.clr_picked = (state_ff == S_BURST_GO);
      wr.stamp      = (state_ff == S_LOOK_DONE) && res_found_ff && out_free;
      wr.alloc      = (state_ff == S_PICK_DONE) && out_free;
   end

   // probe launch
   assign p_valid[0] = (state_ff == S_LOOK_GO) || (state_ff == S_PICK_GO);
   assign p_mode[0]  = (state_ff == S_PICK_GO) ? PROBE_VICTIM : PROBE_LOOKUP;
   assign p_key[0]   = blk_ff;
   assign p_found[0] = 1'b0;
   assign p_idx[0]   = '0;
   assign p_stamp[0] = '0;
   assign p_inv[0]   = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lrc_cell #(
         .IW(IW), .BLOCK_BITS(BLOCK_BITS), .IDX(i)
      ) u_cell (
         .clock(clock), .reset(reset),
         .wr(wr), .wr_idx(res_idx_ff), .wr_tag(alloc_tag), .wr_stamp(clock_ff),
         .p_valid_i(p_valid[i]), .p_mode_i(p_mode[i]), .p_key_i(p_key[i]),
         .p_found_i(p_found[i]), .p_idx_i(p_idx[i]), .p_stamp_i(p_stamp[i]),
         .p_inv_i(p_inv[i]),
         .p_valid_o(p_valid[i+1]), .p_mode_o(p_mode[i+1]), .p_key_o(p_key[i+1]),
         .p_found_o(p_found[i+1]), .p_idx_o(p_idx[i+1]), .p_stamp_o(p_stamp[i+1]),
         .p_inv_o(p_inv[i+1])
      );
   end

   // sequencer and output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         clock_ff     <= '0;
      end else begin
         if (post_word) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff    <= req_tuser;
                  blk_ff   <= blk_ext[BLOCK_BITS-1:0];
                  cnt_ff   <= cnt_req;
                  state_ff <= S_START;
               end
            end
            S_START: begin
               if (op_ff == OP_INV) begin
                  if (out_free) begin
                     kind_ff      <= KIND_INV;
                     idx_out_ff   <= '0;
                     tag_out_ff   <= '0;
                     off_out_ff   <= '0;
                     last_ff      <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               end else if (cnt_ff == '0) begin
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_LOOK_GO;
               end
            end
            S_LOOK_GO: begin
               clock_ff <= clock_ff + 32'd1;
               state_ff <= S_LOOK_WAIT;
            end
            S_LOOK_WAIT: begin
               if (p_valid[ENTRIES]) begin
                  res_found_ff <= p_found[ENTRIES];
                  res_idx_ff   <= p_idx[ENTRIES];
                  state_ff     <= S_LOOK_DONE;
               end
            end
            S_LOOK_DONE: begin
               if (!res_found_ff) begin
                  state_ff <= S_BURST_GO;
               end else if (out_free) begin
                  kind_ff      <= KIND_HIT;
                  idx_out_ff   <= idx_ext[3:0];
                  tag_out_ff   <= tag_ext[31:0];
                  off_out_ff   <= '0;
                  last_ff      <= (cnt_ff == CNT_W'(1));
                  cnt_ff       <= cnt_ff - CNT_W'(1);
                  blk_ff       <= blk_ff + BLOCK_BITS'(1);
                  state_ff     <= (cnt_ff == CNT_W'(1)) ? S_IDLE : S_LOOK_GO;
               end
            end
            S_BURST_GO: begin
               clock_ff <= clock_ff + 32'd1;
               n_ff     <= '0;
               state_ff <= S_PICK_GO;
            end
            S_PICK_GO: begin
               state_ff <= S_PICK_WAIT;
            end
            S_PICK_WAIT: begin
               if (p_valid[ENTRIES]) begin
                  res_idx_ff <= p_idx[ENTRIES];
                  state_ff   <= S_PICK_DONE;
               end
            end
            S_PICK_DONE: begin
               if (out_free) begin
                  kind_ff      <= KIND_ALLOC;
                  idx_out_ff   <= idx_ext[3:0];
                  tag_out_ff   <= tag_ext[31:0];
                  off_out_ff   <= n_ff[3:0];
                  last_ff      <= (n_ff == BURST_C - CNT_W'(1)) && (cnt_ff <= BURST_C);
                  if (n_ff == BURST_C - CNT_W'(1)) begin
                     if (cnt_ff <= BURST_C) begin
                        state_ff <= S_IDLE;
                     end else begin
                        cnt_ff   <= cnt_ff - BURST_C;
                        blk_ff   <= blk_ff + BLOCK_BITS'(BURST);
                        state_ff <= S_BURST_GO;
                     end
                  end else begin
                     n_ff     <= n_ff + CNT_W'(1);
                     state_ff <= S_PICK_GO;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {off_out_ff, tag_out_ff, idx_out_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire
